>>> design/svt_pkg.sv
package svt_pkg;

  localparam int unsigned MAX_VOICES  = 16;
  localparam int unsigned SLOT_W      = $clog2(MAX_VOICES);
  localparam int unsigned CNT_W       = $clog2(MAX_VOICES + 1);

  localparam int unsigned NOTE_W      = 7;
  localparam int unsigned ES_W        = 4;
  localparam int unsigned KIND_W      = 3;
  localparam int unsigned SLOT_OUT_W  = 4;
  localparam int unsigned AFF_W       = 5;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [3:0]        NIB_NOTE_OFF   = 4'h8;
  localparam logic [3:0]        NIB_NOTE_ON    = 4'h9;
  localparam logic [3:0]        NIB_CTRL       = 4'hB;
  localparam logic [NOTE_W-1:0] SUSTAIN_CC     = 7'd64;
  localparam logic [NOTE_W-1:0] SUSTAIN_THRESH = 7'd64;

  typedef enum logic [KIND_W-1:0] {
    KIND_IGNORED      = 3'd0,
    KIND_STARTED      = 3'd1,
    KIND_RELEASED     = 3'd2,
    KIND_HOLD_CHANGED = 3'd3,
    KIND_FREED        = 3'd4,
    KIND_DROPPED      = 3'd5
  } kind_e;

  typedef enum logic [2:0] {
    CMD_IGNORE,
    CMD_FREE,
    CMD_NOTE_ON,
    CMD_NOTE_OFF,
    CMD_SUSTAIN
  } cmd_e;

  typedef enum logic {
    BK_IDLE,
    BK_WALK
  } bk_state_e;

  typedef struct packed {
    cmd_e              op;
    logic [NOTE_W-1:0] note;
    logic              sus_en;
    logic [SLOT_W-1:0] slot;
  } cmd_t;

endpackage

>>> design/svt_front.sv
module svt_front (
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic                      op_i,
  input  logic [7:0]                status_byte_i,
  input  logic [svt_pkg::NOTE_W-1:0] data1_i,
  input  logic [svt_pkg::NOTE_W-1:0] data2_i,
  input  logic [svt_pkg::ES_W-1:0]  ended_slot_i,
  input  logic                      q_full_i,
  output logic                      push_o,
  output svt_pkg::cmd_t             cmd_o
);
  import svt_pkg::*;

  logic [3:0] nib;
  logic       es_ok;

  assign nib        = status_byte_i[7:4];
  assign es_ok      = ({1'b0, ended_slot_i} < (ES_W + 1)'(MAX_VOICES));
  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  always_comb begin
    cmd_o.op     = CMD_IGNORE;
    cmd_o.note   = data1_i;
    cmd_o.sus_en = (data2_i > SUSTAIN_THRESH);
    cmd_o.slot   = SLOT_W'(ended_slot_i);
    if (op_i) begin
      if (es_ok) cmd_o.op = CMD_FREE;
    end else begin
      unique case (nib)
        NIB_NOTE_ON:  cmd_o.op = CMD_NOTE_ON;
        NIB_NOTE_OFF: cmd_o.op = CMD_NOTE_OFF;
        NIB_CTRL: begin
          if (data1_i == SUSTAIN_CC) cmd_o.op = CMD_SUSTAIN;
        end
        default:      cmd_o.op = CMD_IGNORE;
      endcase
    end
  end

endmodule

>>> design/svt_cmd_fifo.sv
module svt_cmd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  svt_pkg::cmd_t wdata_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output svt_pkg::cmd_t rdata_o
);
  import svt_pkg::*;

  cmd_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              do_pop;

  assign full_o  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign rdata_o = mem_q[rd_q];
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

endmodule

>>> design/svt_back.sv
module svt_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cmd_valid_i,
  input  svt_pkg::cmd_t                 cmd_i,
  output logic                          cmd_pop_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [svt_pkg::KIND_W-1:0]    result_kind_o,
  output logic [svt_pkg::SLOT_OUT_W-1:0] slot_o,
  output logic [svt_pkg::AFF_W-1:0]     affected_o,
  output logic [svt_pkg::AFF_W-1:0]     voices_in_use_o
);
  import svt_pkg::*;

  bk_state_e         state_q, state_d;
  cmd_t              cur_q, cur_d;
  logic [SLOT_W-1:0] idx_q, idx_d;
  logic [CNT_W-1:0]  aff_q, aff_d;
  logic [CNT_W-1:0]  use_q, use_d;
  logic [MAX_VOICES-1:0] used_q, used_d;
  logic [MAX_VOICES-1:0] active_q, active_d;
  logic [MAX_VOICES-1:0] held_q, held_d;
  logic              sustain_q, sustain_d;
  logic [NOTE_W-1:0] note_q [MAX_VOICES];
  logic              note_we;

  logic              out_valid_q, out_valid_d;
  kind_e             kind_q, kind_d;
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic [CNT_W-1:0]  oaff_q, oaff_d;
  logic [CNT_W-1:0]  ouse_q, ouse_d;

  logic start, needs_walk, last, walk_done;

  assign start      = (state_q == BK_IDLE) && cmd_valid_i && !out_valid_q;
  assign needs_walk = (cmd_i.op == CMD_NOTE_ON) || (cmd_i.op == CMD_NOTE_OFF) ||
                      ((cmd_i.op == CMD_SUSTAIN) && (cmd_i.sus_en != sustain_q) &&
                       !cmd_i.sus_en);
  assign last       = (idx_q == SLOT_W'(MAX_VOICES - 1));
  assign walk_done  = (state_q == BK_WALK) &&
                      (last || ((cur_q.op == CMD_NOTE_ON) && !used_q[idx_q]));
  assign cmd_pop_o  = start;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: begin
        if (start && needs_walk) state_d = BK_WALK;
      end
      BK_WALK: begin
        if (walk_done) state_d = BK_IDLE;
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    cur_d       = cur_q;
    idx_d       = idx_q;
    aff_d       = aff_q;
    use_d       = use_q;
    used_d      = used_q;
    active_d    = active_q;
    held_d      = held_q;
    sustain_d   = sustain_q;
    note_we     = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;
    kind_d      = kind_q;
    slot_d      = slot_q;
    oaff_d      = oaff_q;
    ouse_d      = ouse_q;

    if (start) begin
      cur_d  = cmd_i;
      idx_d  = '0;
      aff_d  = '0;
      kind_d = KIND_IGNORED;
      slot_d = '0;
      oaff_d = '0;
      ouse_d = use_q;
      if (!needs_walk) out_valid_d = 1'b1;
      case (cmd_i.op)
        CMD_FREE: begin
          if (used_q[cmd_i.slot]) begin
            used_d[cmd_i.slot]   = 1'b0;
            active_d[cmd_i.slot] = 1'b0;
            held_d[cmd_i.slot]   = 1'b0;
            use_d  = use_q - 1'b1;
            ouse_d = use_d;
            kind_d = KIND_FREED;
            slot_d = cmd_i.slot;
            oaff_d = CNT_W'(1);
          end
        end
        CMD_SUSTAIN: begin
          if (cmd_i.sus_en != sustain_q) begin
            sustain_d = cmd_i.sus_en;
            kind_d    = KIND_HOLD_CHANGED;
          end
        end
        default: ;
      endcase
    end else if (state_q == BK_WALK) begin
      idx_d = idx_q + 1'b1;
      case (cur_q.op)
        CMD_NOTE_ON: begin
          if (!used_q[idx_q]) begin
            used_d[idx_q]   = 1'b1;
            active_d[idx_q] = 1'b1;
            held_d[idx_q]   = 1'b0;
            note_we         = 1'b1;
            use_d  = use_q + 1'b1;
            kind_d = KIND_STARTED;
            slot_d = idx_q;
          end else begin
            kind_d = KIND_DROPPED;
          end
        end
        CMD_NOTE_OFF: begin
          kind_d = KIND_RELEASED;
          if (used_q[idx_q] && active_q[idx_q] && (note_q[idx_q] == cur_q.note)) begin
            if (sustain_q) begin
              held_d[idx_q] = 1'b1;
            end else begin
              active_d[idx_q] = 1'b0;
              held_d[idx_q]   = 1'b0;
            end
            aff_d = aff_q + 1'b1;
          end
        end
        default: begin
          kind_d = KIND_HOLD_CHANGED;
          if (used_q[idx_q] && held_q[idx_q]) begin
            active_d[idx_q] = 1'b0;
            held_d[idx_q]   = 1'b0;
            aff_d = aff_q + 1'b1;
          end
        end
      endcase
      oaff_d = aff_d;
      ouse_d = use_d;
      if (walk_done) out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      use_q       <= '0;
      used_q      <= '0;
      active_q    <= '0;
      held_q      <= '0;
      sustain_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      use_q       <= use_d;
      used_q      <= used_d;
      active_q    <= active_d;
      held_q      <= held_d;
      sustain_q   <= sustain_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    idx_q  <= idx_d;
    aff_q  <= aff_d;
    kind_q <= kind_d;
    slot_q <= slot_d;
    oaff_q <= oaff_d;
    ouse_q <= ouse_d;
    if (note_we) begin
      note_q[idx_q] <= cur_q.note;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign result_kind_o   = kind_q;
  assign slot_o          = SLOT_OUT_W'(slot_q);
  assign affected_o      = AFF_W'(oaff_q);
  assign voices_in_use_o = AFF_W'(ouse_q);

  a_use_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(use_q) == 32'($countones(used_q)))
    else $error("use count out of step with occupied slots");

  a_held_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (held_q & ~(used_q & active_q)) == '0)
    else $error("held voice not active");

  a_no_held_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_IDLE) && !sustain_q |-> held_q == '0)
    else $error("held voice left after sustain off");

  a_walk_out_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == BK_WALK |-> !out_valid_q)
    else $error("walk running while result pending");

  a_slot_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (kind_q != KIND_STARTED) && (kind_q != KIND_FREED) |-> slot_q == '0)
    else $error("slot set for kind without slot");

endmodule

>>> design/synth_voice_table.sv
// Polyphonic voice table with sustain pedal.
// Input channel: in_valid_i / in_stall_o carry one item, either a decoded
// MIDI channel message (op_i = 0) or a voice-ended report (op_i = 1).
// Output channel: out_valid_o / out_stall_i return exactly one result item
// per input item, in order.
// An item is decoded on entry and parked in a two-entry command queue; the
// back end takes one command at a time. Free, ignored, sustain-on and
// unchanged sustain items finish without a walk. Note-on walks the slots
// from zero up to the first free one; note-off and sustain-off walk all
// MAX_VOICES slots. The back end starts no new command while a result is
// still waiting on the output.
// Reset empties the table, clears sustain and empties the queue.
// While out_stall_i holds the result, the back end waits; the queue fills
// and then in_stall_o rises. time_stamp_i is accepted but not stored.
module synth_voice_table (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            op_i,
  input  logic [7:0]                      status_byte_i,
  input  logic [svt_pkg::NOTE_W-1:0]      data1_i,
  input  logic [svt_pkg::NOTE_W-1:0]      data2_i,
  input  logic [31:0]                     time_stamp_i,
  input  logic [svt_pkg::ES_W-1:0]        ended_slot_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [svt_pkg::KIND_W-1:0]      result_kind_o,
  output logic [svt_pkg::SLOT_OUT_W-1:0]  slot_o,
  output logic [svt_pkg::AFF_W-1:0]       affected_o,
  output logic [svt_pkg::AFF_W-1:0]       voices_in_use_o
);
  import svt_pkg::*;

  logic push, q_full, q_valid, pop;
  cmd_t cmd_in, cmd_out;

  svt_front u_front (
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .op_i          (op_i),
    .status_byte_i (status_byte_i),
    .data1_i       (data1_i),
    .data2_i       (data2_i),
    .ended_slot_i  (ended_slot_i),
    .q_full_i      (q_full),
    .push_o        (push),
    .cmd_o         (cmd_in)
  );

  svt_cmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (cmd_in),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .rdata_o (cmd_out)
  );

  svt_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_valid_i     (q_valid),
    .cmd_i           (cmd_out),
    .cmd_pop_o       (pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .result_kind_o   (result_kind_o),
    .slot_o          (slot_o),
    .affected_o      (affected_o),
    .voices_in_use_o (voices_in_use_o)
  );

endmodule
